// ===== rtl/core/pbfl_pkg.sv =====
package pbfl_pkg;

	// default channel geometry
	localparam int SENSORS_DEF = 2;
	localparam int KEYS_DEF    = 7;

	// field and state widths
	localparam int SIG_W     = 16;
	localparam int FILT_W    = 22;
	localparam int FRAC_W    = 6;
	localparam int SUM_W     = 26;
	localparam int CNT_W     = 10;
	localparam int ALPHA_W   = 9;
	localparam int EN_W      = 14;
	localparam int EN_IDX_W  = 4;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;

	localparam logic [FILT_W-1:0] FILT_MAX = {FILT_W{1'b1}};
	localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BASELINE_SAMPLES = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FILTER_ALPHA     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IGNORE_LIMIT     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CLOSED_THRESHOLD = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_ENABLE   = 3'd4;

	// register reset values
	localparam logic [CNT_W-1:0]   RST_BASELINE_SAMPLES = 10'd100;
	localparam logic [ALPHA_W-1:0] RST_FILTER_ALPHA     = 9'd205;
	localparam logic [SIG_W-1:0]   RST_IGNORE_LIMIT     = 16'd1000;
	localparam logic [SIG_W-1:0]   RST_CLOSED_THRESHOLD = 16'd300;
	localparam logic [EN_W-1:0]    RST_CHANNEL_ENABLE   = 14'd8079;

	typedef struct packed {
		logic             kind;
		logic             sensor;
		logic [2:0]       key;
		logic [SIG_W-1:0] signal;
	} in_item_t;

	typedef struct packed {
		logic              sensor_out;
		logic [2:0]        key_out;
		logic [FILT_W-1:0] filtered_delta;
		logic              closed;
		logic              baseline_ready;
		logic              active;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic decide;
		logic div_start;
		logic set_base;
		logic mul;
		logic acc;
		logic emit;
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clear;
		logic skip;
		logic base_done;
		logic form;
		logic div_done;
		logic out_free;
	} ctl_sts_t;

endpackage

// ===== rtl/core/pbfl_div.sv =====
module pbfl_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [pbfl_pkg::SUM_W-1:0] dividend,
	input  logic [pbfl_pkg::CNT_W-1:0] divisor,
	output logic                       done,
	output logic [pbfl_pkg::SUM_W-1:0] quotient
);
	import pbfl_pkg::*;

	localparam int STEP_W = $clog2(SUM_W);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  div_q;
	logic [SUM_W-1:0]  quo_q;

	logic [CNT_W:0] trial;
	logic           ge;

	// one restoring step: shift in next dividend bit, subtract if it fits
	always_comb begin
		trial = {rem_q, quo_q[SUM_W-1]};
		ge    = trial >= {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(SUM_W - 1);
			end else if (busy_q) begin
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - 1'b1;
				end
			end
		end
	end

	// remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			div_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? CNT_W'(trial - {1'b0, div_q}) : trial[CNT_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== rtl/core/pbfl_ctrl.sv =====
module pbfl_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  pbfl_pkg::ctl_sts_t sts,
	output pbfl_pkg::ctl_cmd_t cmd,
	output logic               busy
);
	import pbfl_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_DIV,
		S_MUL,
		S_ACC,
		S_OUT
	} state_t;

	state_t state_q;
	logic   busy_q;

	// commands decoded from the current state
	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				cmd.load = start;
			end
			S_DECIDE: begin
				cmd.decide    = 1'b1;
				cmd.div_start = !sts.clear && !sts.skip && !sts.base_done && sts.form;
			end
			S_DIV: begin
				cmd.set_base = sts.div_done;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
			end
			S_ACC: begin
				cmd.acc = 1'b1;
			end
			S_OUT: begin
				cmd.emit = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// state and busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_DECIDE;
						busy_q  <= 1'b1;
					end
				end
				S_DECIDE: begin
					if (sts.clear || sts.skip) begin
						state_q <= S_OUT;
					end else if (!sts.base_done) begin
						state_q <= sts.form ? S_DIV : S_OUT;
					end else begin
						state_q <= S_MUL;
					end
				end
				S_DIV: begin
					if (sts.div_done) begin
						state_q <= S_OUT;
					end
				end
				S_MUL: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (sts.out_free) begin
						state_q <= S_IDLE;
						busy_q  <= 1'b0;
					end
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	assign busy = busy_q;

endmodule

// ===== rtl/core/pbfl_dp.sv =====
module pbfl_dp #(
	parameter int SENSORS = pbfl_pkg::SENSORS_DEF,
	parameter int KEYS    = pbfl_pkg::KEYS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [pbfl_pkg::CFG_IDX_W-1:0] cfg_addr,
	input  logic [pbfl_pkg::CFG_W-1:0]     cfg_data,
	input  pbfl_pkg::in_item_t             in_data,
	input  pbfl_pkg::ctl_cmd_t             cmd,
	output pbfl_pkg::ctl_sts_t             sts,
	output logic                           out_valid,
	input  logic                           out_stall,
	output pbfl_pkg::out_item_t            out_data
);
	import pbfl_pkg::*;

	localparam int NCH   = SENSORS * KEYS;
	localparam int CH_W  = (NCH > 1) ? $clog2(NCH) : 1;
	localparam int CHX_W = CH_W + 5;
	localparam int PA_W  = ALPHA_W + SIG_W;
	localparam int PF_W  = ALPHA_W + FILT_W;
	localparam int ACC_W = PF_W + 1;

	// configuration registers
	logic [CNT_W-1:0]   base_samples_q;
	logic [ALPHA_W-1:0] alpha_q;
	logic [SIG_W-1:0]   ignore_q;
	logic [SIG_W-1:0]   thresh_q;
	logic [EN_W-1:0]    enable_q;

	// per-channel state
	logic [SUM_W-1:0]  sum_q  [NCH];
	logic [CNT_W-1:0]  cnt_q  [NCH];
	logic [SIG_W-1:0]  base_q [NCH];
	logic              bd_q   [NCH];
	logic [FILT_W-1:0] fv_q   [NCH];
	logic              cl_q   [NCH];

	// item in flight
	in_item_t          item_s1;
	logic [CH_W-1:0]   ch_s1;
	logic              skip_s1;
	logic              zero_s1;
	logic              act_s1;
	logic [SIG_W-1:0]  delta_s1;
	logic [PA_W-1:0]   pa_s2;
	logic [PF_W-1:0]   pf_s2;

	out_item_t out_q;
	logic      out_valid_q;

	logic [CHX_W-1:0]   chx;
	logic               in_rng;
	logic               in_en;
	logic [SUM_W-1:0]   rd_sum;
	logic [CNT_W-1:0]   rd_cnt;
	logic [SIG_W-1:0]   rd_base;
	logic               rd_bd;
	logic [FILT_W-1:0]  rd_fv;
	logic               rd_cl;
	logic [SUM_W-1:0]   new_sum;
	logic [CNT_W-1:0]   new_cnt;
	logic [CNT_W-1:0]   need;
	logic [SIG_W:0]     diff;
	logic [SIG_W-1:0]   delta;
	logic [ALPHA_W-1:0] alpha_sat;
	logic [ACC_W-1:0]   acc;
	logic [ACC_W-9:0]   acc_sh;
	logic [FILT_W-1:0]  fnew;
	logic               div_done;
	logic [SUM_W-1:0]   quot;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_samples_q <= RST_BASELINE_SAMPLES;
			alpha_q        <= RST_FILTER_ALPHA;
			ignore_q       <= RST_IGNORE_LIMIT;
			thresh_q       <= RST_CLOSED_THRESHOLD;
			enable_q       <= RST_CHANNEL_ENABLE;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_BASELINE_SAMPLES: base_samples_q <= cfg_data[CNT_W-1:0];
				REG_FILTER_ALPHA:     alpha_q        <= cfg_data[ALPHA_W-1:0];
				REG_IGNORE_LIMIT:     ignore_q       <= cfg_data[SIG_W-1:0];
				REG_CLOSED_THRESHOLD: thresh_q       <= cfg_data[SIG_W-1:0];
				REG_CHANNEL_ENABLE:   enable_q       <= cfg_data[EN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// channel number and its checks for the incoming beat
	always_comb begin
		chx    = CHX_W'(in_data.sensor) * CHX_W'(KEYS) + CHX_W'(in_data.key);
		in_rng = (int'(in_data.sensor) < SENSORS) && (int'(in_data.key) < KEYS);
		in_en  = (int'(chx) < EN_W) && enable_q[chx[EN_IDX_W-1:0]];
	end

	// capture the item
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_s1 <= in_data;
			ch_s1   <= in_rng ? chx[CH_W-1:0] : '0;
			skip_s1 <= !(in_rng && in_en);
			zero_s1 <= in_data.kind || !in_rng;
		end
	end

	// channel state reads
	always_comb begin
		rd_sum  = sum_q[ch_s1];
		rd_cnt  = cnt_q[ch_s1];
		rd_base = base_q[ch_s1];
		rd_bd   = bd_q[ch_s1];
		rd_fv   = fv_q[ch_s1];
		rd_cl   = cl_q[ch_s1];
	end

	// baseline accumulation and the count that forms it
	always_comb begin
		new_sum = rd_sum + SUM_W'(item_s1.signal);
		new_cnt = rd_cnt + 1'b1;
		need    = (base_samples_q == '0) ? CNT_W'(1) : base_samples_q;
	end

	// delta against baseline, zeroed when negative or past the ignore limit
	always_comb begin
		diff  = {1'b0, item_s1.signal} - {1'b0, rd_base};
		delta = (diff[SIG_W] || diff[SIG_W-1:0] > ignore_q) ? '0 : diff[SIG_W-1:0];
	end

	// filter update: weighted sum, round half up, saturate
	always_comb begin
		alpha_sat = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
		acc       = ACC_W'({pa_s2, {FRAC_W{1'b0}}}) + ACC_W'(pf_s2) + ACC_W'(128);
		acc_sh    = acc[ACC_W-1:8];
		fnew      = (acc_sh > (ACC_W-8)'(FILT_MAX)) ? FILT_MAX : acc_sh[FILT_W-1:0];
	end

	pbfl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (new_sum),
		.divisor  (new_cnt),
		.done     (div_done),
		.quotient (quot)
	);

	// delta, products and the active flag
	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			delta_s1 <= delta;
			act_s1   <= !item_s1.kind && !skip_s1 && rd_bd;
		end
		if (cmd.mul) begin
			pa_s2 <= PA_W'(alpha_sat) * PA_W'(delta_s1);
			pf_s2 <= PF_W'(ALPHA_ONE - alpha_sat) * PF_W'(rd_fv);
		end
	end

	// per-channel state with reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NCH; i++) begin
				sum_q[i] <= '0;
				cnt_q[i] <= '0;
				bd_q[i]  <= 1'b0;
				fv_q[i]  <= '0;
				cl_q[i]  <= 1'b0;
			end
		end else begin
			if (cmd.decide && item_s1.kind) begin
				for (int i = 0; i < NCH; i++) begin
					cl_q[i] <= 1'b0;
				end
			end else if (cmd.decide && !skip_s1 && !rd_bd) begin
				sum_q[ch_s1] <= new_sum;
				cnt_q[ch_s1] <= new_cnt;
			end
			if (cmd.set_base) begin
				bd_q[ch_s1] <= 1'b1;
			end
			if (cmd.acc) begin
				fv_q[ch_s1] <= fnew;
				if (fnew[FILT_W-1:FRAC_W] >= thresh_q) begin
					cl_q[ch_s1] <= 1'b1;
				end
			end
		end
	end

	// baseline store, written once its mean is formed
	always_ff @(posedge clk) begin
		if (cmd.set_base) begin
			base_q[ch_s1] <= quot[SIG_W-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.sensor_out     <= item_s1.sensor;
			out_q.key_out        <= item_s1.key;
			out_q.filtered_delta <= zero_s1 ? '0 : rd_fv;
			out_q.closed         <= zero_s1 ? 1'b0 : rd_cl;
			out_q.baseline_ready <= zero_s1 ? 1'b0 : rd_bd;
			out_q.active         <= act_s1;
		end
	end

	always_comb begin
		sts.clear     = item_s1.kind;
		sts.skip      = skip_s1;
		sts.base_done = rd_bd;
		sts.form      = new_cnt >= need;
		sts.div_done  = div_done;
		sts.out_free  = !out_valid_q || !out_stall;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== rtl/core/proximity_baseline_filter_latch.sv =====
// Baseline-subtracting proximity filter with a closed latch per channel.
// Each beat carries one key sample (or a clear-all-latches command); every
// beat gives exactly one result. An item is worked on alone: a sample on a
// filtering channel passes decide, multiply, accumulate and output after
// acceptance; a baseline sample, a clear or a skipped channel only decide and
// output. The sample that completes a baseline also waits in a divide state
// while the 26-step restoring divider forms the mean. Input stall is high while
// an item is in work; the next item is taken as soon as the result has moved
// into the output register, even if that register still waits downstream.
module proximity_baseline_filter_latch #(
	parameter int SENSORS = pbfl_pkg::SENSORS_DEF,
	parameter int KEYS    = pbfl_pkg::KEYS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [pbfl_pkg::CFG_IDX_W-1:0] cfg_addr,
	input  logic [pbfl_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  pbfl_pkg::in_item_t             in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output pbfl_pkg::out_item_t            out_data
);
	import pbfl_pkg::*;

	ctl_cmd_t cmd;
	ctl_sts_t sts;
	logic     busy;
	logic     in_accept;

	// input beat taken only while the controller is free
	assign in_stall  = busy;
	assign in_accept = in_valid && !busy;

	pbfl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_accept),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	pbfl_dp #(
		.SENSORS (SENSORS),
		.KEYS    (KEYS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

`ifndef NO_ASSERTIONS
	// one item at a time: an accepted beat blocks the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> in_stall)
		else $error("input accepted while an item is in work");

	// a filtered result always comes from a formed baseline
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.active |-> out_data.baseline_ready)
		else $error("active result without baseline");

	// a result is only loaded while the item is still in work
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(busy))
		else $error("result appeared with no item in work");
`endif

endmodule

// ===== tb/testbench.sv =====
module testbench;
	import pbfl_pkg::*;

	localparam int NCH = SENSORS_DEF * KEYS_DEF;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_addr = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	in_item_t         in_data = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	out_item_t        out_data;

	// beats waiting to be sent and results still owed by the block
	in_item_t  pending_beats[$];
	out_item_t expected_results[$];
	out_item_t want;
	int        errors = 0;
	int        idle_pct = 20;
	int        stall_pct = 20;

	// predictor copy of the registers
	logic [CNT_W-1:0]   cfg_bs = RST_BASELINE_SAMPLES;
	logic [ALPHA_W-1:0] cfg_alpha = RST_FILTER_ALPHA;
	logic [SIG_W-1:0]   cfg_ignore = RST_IGNORE_LIMIT;
	logic [SIG_W-1:0]   cfg_thr = RST_CLOSED_THRESHOLD;
	logic [EN_W-1:0]    cfg_en = RST_CHANNEL_ENABLE;

	// predictor copy of the per-channel state
	logic [SUM_W-1:0]  acc_sum[NCH];
	logic [CNT_W-1:0]  acc_cnt[NCH];
	logic [SIG_W-1:0]  base_val[NCH];
	logic              base_done[NCH];
	logic [FILT_W-1:0] filt_val[NCH];
	logic              latch[NCH];

	// nominal signal level per channel, steers the stimulus only
	int level[NCH];

	proximity_baseline_filter_latch uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// expected result of one beat, updates the channel state
	function automatic out_item_t filter_step(in_item_t it);
		out_item_t    r;
		int unsigned  ch;
		logic [CNT_W-1:0] need;
		longint unsigned a;
		longint unsigned delta;
		longint unsigned acc;
		r = '0;
		r.sensor_out = it.sensor;
		r.key_out = it.key;
		if (it.kind) begin
			for (int i = 0; i < NCH; i++)
				latch[i] = 1'b0;
			return r;
		end
		if (it.sensor >= SENSORS_DEF || it.key >= KEYS_DEF)
			return r;
		ch = it.sensor * KEYS_DEF + it.key;
		r.filtered_delta = filt_val[ch];
		r.closed = latch[ch];
		r.baseline_ready = base_done[ch];
		if (!cfg_en[ch])
			return r;
		// still collecting the baseline
		if (!base_done[ch]) begin
			need = (cfg_bs == 0) ? CNT_W'(1) : cfg_bs;
			acc_sum[ch] = acc_sum[ch] + it.signal;
			acc_cnt[ch] = acc_cnt[ch] + 1'b1;
			if (acc_cnt[ch] >= need) begin
				base_val[ch] = (acc_cnt[ch] != 0) ? SIG_W'(acc_sum[ch] / acc_cnt[ch]) : '0;
				base_done[ch] = 1'b1;
			end
			r.baseline_ready = base_done[ch];
			return r;
		end
		// delta, then the exponential filter
		if (it.signal < base_val[ch] || it.signal - base_val[ch] > cfg_ignore)
			delta = 0;
		else
			delta = it.signal - base_val[ch];
		a = (cfg_alpha > ALPHA_ONE) ? ALPHA_ONE : cfg_alpha;
		acc = (a * delta * 64 + (256 - a) * filt_val[ch] + 128) >> 8;
		if (acc > FILT_MAX)
			acc = FILT_MAX;
		filt_val[ch] = acc[FILT_W-1:0];
		if ((filt_val[ch] >> FRAC_W) >= cfg_thr)
			latch[ch] = 1'b1;
		r.filtered_delta = filt_val[ch];
		r.closed = latch[ch];
		r.baseline_ready = 1'b1;
		r.active = 1'b1;
		return r;
	endfunction

	function automatic in_item_t beat(logic kind, logic sensor, logic [2:0] key,
			logic [SIG_W-1:0] sig);
		in_item_t it;
		it.kind = kind;
		it.sensor = sensor;
		it.key = key;
		it.signal = sig;
		return it;
	endfunction

	// mostly samples near the channel level, some clears, bad keys and noise
	function automatic in_item_t random_beat();
		in_item_t    it;
		int unsigned ch;
		int unsigned pick;
		int          span;
		int          lvl;
		it = '0;
		pick = $urandom_range(99);
		if (pick < 5) begin
			it = beat(1'b1, 1'($urandom), 3'($urandom), 16'($urandom));
		end else if (pick < 9) begin
			it = beat(1'b0, 1'($urandom), 3'd7, 16'($urandom));
		end else begin
			ch = $urandom_range(NCH - 1);
			span = int'(cfg_ignore) + int'(cfg_ignore) / 4 + 1;
			pick = $urandom_range(99);
			if (pick < 10)
				lvl = int'($urandom_range(65535));
			else if (pick < 20)
				lvl = level[ch] - int'($urandom_range(1, 2000));
			else
				lvl = level[ch] + int'($urandom_range(span));
			if (lvl < 0)
				lvl = 0;
			if (lvl > 65535)
				lvl = 65535;
			it = beat(1'b0, 1'(ch / KEYS_DEF), 3'(ch % KEYS_DEF), lvl[15:0]);
		end
		return it;
	endfunction

	task automatic write_reg(input int idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= CFG_IDX_W'(idx);
		cfg_data <= val;
		case (CFG_IDX_W'(idx))
			REG_BASELINE_SAMPLES: cfg_bs = val[CNT_W-1:0];
			REG_FILTER_ALPHA:     cfg_alpha = val[ALPHA_W-1:0];
			REG_IGNORE_LIMIT:     cfg_ignore = val;
			REG_CLOSED_THRESHOLD: cfg_thr = val;
			REG_CHANNEL_ENABLE:   cfg_en = val[EN_W-1:0];
			default: ;
		endcase
	endtask

	task automatic program_regs(input int bs, input int alpha, input int ign,
			input int thr, input int en);
		write_reg(REG_BASELINE_SAMPLES, CFG_W'(bs));
		write_reg(REG_FILTER_ALPHA, CFG_W'(alpha));
		write_reg(REG_IGNORE_LIMIT, CFG_W'(ign));
		write_reg(REG_CLOSED_THRESHOLD, CFG_W'(thr));
		write_reg(REG_CHANNEL_ENABLE, CFG_W'(en));
		@(posedge clk);
		cfg_we <= 1'b0;
		// stimulus follows the settled baselines
		for (int i = 0; i < NCH; i++)
			if (base_done[i])
				level[i] = base_val[i];
		@(negedge clk);
	endtask

	// wait until every beat is sent and every result is back
	task automatic drain();
		@(posedge clk);
		while (pending_beats.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic string show(out_item_t r);
		return $sformatf("sensor=%0d key=%0d filt=%0d closed=%0d ready=%0d active=%0d",
			r.sensor_out, r.key_out, r.filtered_delta, r.closed, r.baseline_ready,
			r.active);
	endfunction

	// input driver, predicts each accepted beat
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				expected_results.push_back(filter_step(in_data));
			if (!in_valid || !in_stall) begin
				if (pending_beats.size() != 0 && $urandom_range(99) >= idle_pct) begin
					in_valid <= 1'b1;
					in_data <= pending_beats.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output monitor with random back-pressure
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result, got %s", $time, show(out_data));
					errors++;
				end else begin
					want = expected_results.pop_front();
					if (out_data !== want) begin
						$display("%0t: mismatch, expected %s, got %s", $time, show(want),
							show(out_data));
						errors++;
					end
				end
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	initial begin
		int alpha;
		int ign;
		int thr;
		int en;

		for (int i = 0; i < NCH; i++) begin
			acc_sum[i] = '0;
			acc_cnt[i] = '0;
			base_val[i] = '0;
			base_done[i] = 1'b0;
			filt_val[i] = '0;
			latch[i] = 1'b0;
			level[i] = int'($urandom_range(65535));
		end
		level[3] = 0;
		level[9] = 65535;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: clear, bad keys, disabled channels, early baseline samples
		pending_beats.push_back(beat(1'b1, 1'b1, 3'd7, 16'hFFFF));
		pending_beats.push_back(beat(1'b0, 1'b0, 3'd7, 16'hFFFF));
		pending_beats.push_back(beat(1'b0, 1'b1, 3'd7, 16'h0000));
		pending_beats.push_back(beat(1'b0, 1'b0, 3'd4, 16'h0000));
		pending_beats.push_back(beat(1'b0, 1'b1, 3'd6, 16'hFFFF));
		pending_beats.push_back(beat(1'b0, 1'b0, 3'd0, 16'h0000));
		pending_beats.push_back(beat(1'b0, 1'b0, 3'd0, 16'hFFFF));
		pending_beats.push_back(beat(1'b0, 1'b0, 3'd0, 16'd1000));
		drain();

		// writes past the register list must be ignored
		for (int i = REG_CHANNEL_ENABLE + 1; i < (1 << CFG_IDX_W); i++)
			write_reg(i, CFG_W'($urandom));
		// zero sample count acts as one, full alpha, widest limits
		program_regs(0, 256, 65535, 65535, 'h03FF);
		pending_beats.push_back(beat(1'b0, 1'b0, 3'd0, 16'd123));
		pending_beats.push_back(beat(1'b0, 1'b0, 3'd1, 16'hFFFF));
		pending_beats.push_back(beat(1'b0, 1'b0, 3'd1, 16'hFFFF));
		pending_beats.push_back(beat(1'b0, 1'b0, 3'd1, 16'h0000));
		pending_beats.push_back(beat(1'b0, 1'b0, 3'd2, 16'h0000));
		pending_beats.push_back(beat(1'b0, 1'b0, 3'd2, 16'hFFFF));
		pending_beats.push_back(beat(1'b1, 1'b0, 3'd0, 16'h0000));
		pending_beats.push_back(beat(1'b0, 1'b0, 3'd2, 16'hFFFF));
		pending_beats.push_back(beat(1'b0, 1'b1, 3'd3, 16'd4242));
		pending_beats.push_back(beat(1'b0, 1'b1, 3'd0, 16'd777));
		drain();

		// random phases
		for (int ph = 0; ph < 8; ph++) begin
			case ($urandom_range(4))
				0: alpha = 0;
				1: alpha = 256;
				2: alpha = $urandom_range(257, 511);
				default: alpha = $urandom_range(1, 255);
			endcase
			case ($urandom_range(3))
				0: ign = 65535;
				1: ign = $urandom_range(0, 255);
				default: ign = $urandom_range(256, 8000);
			endcase
			thr = ($urandom_range(5) == 0) ? 65535 : $urandom_range(0, ign / 2);
			en = $urandom_range(16383);
			idle_pct = 20;
			stall_pct = 20;
			case (ph)
				// longest baseline, channels still collecting keep summing
				0: program_regs(1023, 205, 1000, 300, 'h3FFF);
				// lowered count lets pending baselines form on their next sample
				1: program_regs($urandom_range(2, 10), 511, ign, thr, 'h3FFF);
				// filter frozen, every delta dropped, latch on anything
				2: program_regs($urandom_range(1, 1023), 0, 0, 0, en);
				// nothing enabled
				4: program_regs($urandom_range(1, 1023), alpha, ign, thr, 0);
				// no idling on either side
				5: begin
					idle_pct = 0;
					stall_pct = 0;
					program_regs($urandom_range(1, 1023), alpha, ign, thr, 'h3FFF);
				end
				default: program_regs($urandom_range(1, 1023), alpha, ign, thr, en);
			endcase
			for (int n = 0; n < 220; n++)
				pending_beats.push_back(random_beat());
			drain();
		end

		repeat (40) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// watchdog
	initial begin
		#20000000;
		$display("status: fail");
		$finish;
	end

endmodule
